// File: rtl/scfp_pkg.sv
package scfp_pkg;

	// Sizes of the payload store and the derived widths.
	localparam int BUFFER_DEPTH = 32;
	localparam int STORE_SIZE   = 32;
	localparam int STORE_LIMIT  = (BUFFER_DEPTH < STORE_SIZE) ? BUFFER_DEPTH : STORE_SIZE;
	localparam int IDX_W        = $clog2(STORE_SIZE);
	localparam int CNT_W        = $clog2(STORE_SIZE + 1);

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_HEAD_MARKER = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL_MARKER = 1'b1;

	// Register values after reset.
	localparam logic [7:0] HEAD_MARKER_RST = 8'h55;
	localparam logic [7:0] TAIL_MARKER_RST = 8'hAA;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_cmd;
		logic cap_len;
		logic store;
		logic csum_step;
		logic start_drain;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic head_match;
		logic tail_match;
		logic len_zero;
		logic store_done;
		logic csum_done;
		logic out_free;
		logic drain_last;
	} sts_t;

endpackage

// File: rtl/scfp_ctrl.sv
module scfp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  scfp_pkg::sts_t  sts,
	output scfp_pkg::cmd_t  cmd
);

	typedef enum logic [7:0] {
		ST_HEAD  = 8'b0000_0001,
		ST_CMD   = 8'b0000_0010,
		ST_LEN   = 8'b0000_0100,
		ST_DATA  = 8'b0000_1000,
		ST_CSUM  = 8'b0001_0000,
		ST_TAIL  = 8'b0010_0000,
		ST_FETCH = 8'b0100_0000,
		ST_EMIT  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   fire;

	// Words are taken in every receive phase; draining holds the input off.
	assign in_ready = state_q inside {ST_HEAD, ST_CMD, ST_LEN, ST_DATA, ST_CSUM, ST_TAIL};
	assign fire     = in_valid && in_ready;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_HEAD: begin
				if (fire && sts.head_match) state_d = ST_CMD;
			end
			ST_CMD: begin
				if (fire) begin
					cmd.cap_cmd = 1'b1;
					state_d     = ST_LEN;
				end
			end
			ST_LEN: begin
				if (fire) begin
					cmd.cap_len = 1'b1;
					state_d     = sts.len_zero ? ST_CSUM : ST_DATA;
				end
			end
			ST_DATA: begin
				if (fire) begin
					cmd.store = 1'b1;
					if (sts.store_done) state_d = ST_CSUM;
				end
			end
			ST_CSUM: begin
				if (fire) begin
					cmd.csum_step = 1'b1;
					if (sts.csum_done) state_d = ST_TAIL;
				end
			end
			ST_TAIL: begin
				if (fire) begin
					if (sts.tail_match) begin
						cmd.start_drain = 1'b1;
						state_d         = ST_FETCH;
					end else begin
						state_d = ST_HEAD;
					end
				end
			end
			ST_FETCH: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = sts.drain_last ? ST_HEAD : ST_FETCH;
				end
			end
			default: begin
				state_d = ST_HEAD;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_HEAD;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/scfp_dp.sv
module scfp_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [scfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic [7:0]                        rx_byte,
	input  scfp_pkg::cmd_t                    cmd,
	output scfp_pkg::sts_t                    sts,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [7:0]                        frame_command,
	output logic [7:0]                        frame_length,
	output logic                              has_payload,
	output logic [7:0]                        payload_byte,
	output logic [4:0]                        payload_position,
	output logic                              last_of_frame
);

	localparam logic [scfp_pkg::CNT_W-1:0] LIMIT = scfp_pkg::CNT_W'(scfp_pkg::STORE_LIMIT);

	logic [7:0]                   head_marker_q;
	logic [7:0]                   tail_marker_q;
	logic [7:0]                   held_command_q;
	logic [7:0]                   held_length_q;
	logic [scfp_pkg::CNT_W-1:0]   stored_count_q;
	logic [1:0]                   checksum_count_q;
	logic [scfp_pkg::IDX_W-1:0]   rd_idx_q;
	logic [7:0]                   rdata_q;
	logic [7:0]                   mem [scfp_pkg::STORE_SIZE];
	logic                         out_valid_q;
	logic [7:0]                   out_cmd_q;
	logic [7:0]                   out_len_q;
	logic                         out_has_q;
	logic [7:0]                   out_byte_q;
	logic [4:0]                   out_pos_q;
	logic                         out_last_q;

	logic                         room;
	logic [scfp_pkg::CNT_W-1:0]   next_count;
	logic [1:0]                   next_csum;
	logic [scfp_pkg::CNT_W-1:0]   rd_next;
	logic                         has_data;

	// Store bookkeeping: room left and the count after this word.
	assign room       = stored_count_q < LIMIT;
	assign next_count = stored_count_q + scfp_pkg::CNT_W'(room);
	assign next_csum  = checksum_count_q + 2'd1;
	assign rd_next    = scfp_pkg::CNT_W'(rd_idx_q) + scfp_pkg::CNT_W'(1);
	assign has_data   = stored_count_q != '0;

	// Status towards the controller.
	always_comb begin
		sts.head_match = rx_byte == head_marker_q;
		sts.tail_match = rx_byte == tail_marker_q;
		sts.len_zero   = rx_byte == 8'd0;
		sts.store_done = ({{(8 - scfp_pkg::CNT_W){1'b0}}, next_count} >= held_length_q)
		                 || (next_count >= LIMIT);
		sts.csum_done  = next_csum >= 2'd2;
		sts.out_free   = !out_valid_q || out_ready;
		sts.drain_last = !has_data || (rd_next >= stored_count_q);
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_marker_q <= scfp_pkg::HEAD_MARKER_RST;
			tail_marker_q <= scfp_pkg::TAIL_MARKER_RST;
		end else if (cfg_wen) begin
			case (cfg_index)
				scfp_pkg::REG_HEAD_MARKER: head_marker_q <= cfg_data;
				scfp_pkg::REG_TAIL_MARKER: tail_marker_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame header, counters and drain index.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_command_q   <= '0;
			held_length_q    <= '0;
			stored_count_q   <= '0;
			checksum_count_q <= '0;
			rd_idx_q         <= '0;
		end else begin
			if (cmd.cap_cmd) held_command_q <= rx_byte;
			if (cmd.cap_len) begin
				held_length_q    <= rx_byte;
				stored_count_q   <= '0;
				checksum_count_q <= '0;
			end
			if (cmd.store) stored_count_q <= next_count;
			if (cmd.csum_step) checksum_count_q <= next_csum;
			if (cmd.start_drain) begin
				rd_idx_q <= '0;
			end else if (cmd.load_out) begin
				rd_idx_q <= rd_next[scfp_pkg::IDX_W-1:0];
			end
		end
	end

	// Payload store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.store && room) begin
			mem[stored_count_q[scfp_pkg::IDX_W-1:0]] <= rx_byte;
		end
		rdata_q <= mem[rd_idx_q];
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_cmd_q  <= held_command_q;
			out_len_q  <= held_length_q;
			out_has_q  <= has_data;
			out_byte_q <= has_data ? rdata_q : 8'd0;
			out_pos_q  <= has_data ? 5'(rd_idx_q) : 5'd0;
			out_last_q <= sts.drain_last;
		end
	end

	assign out_valid        = out_valid_q;
	assign frame_command    = out_cmd_q;
	assign frame_length     = out_len_q;
	assign has_payload      = out_has_q;
	assign payload_byte     = out_byte_q;
	assign payload_position = out_pos_q;
	assign last_of_frame    = out_last_q;

endmodule

// File: rtl/serial_command_frame_parser.sv
// Receive words are taken one per cycle while a frame is being parsed.
// With the output side ready, a good tail word resets the drain index, and each result
// then takes a payload store read into a register and a load of the output word.
// A frame with no stored bytes drains as one word; output stalls stretch the drain,
// and no word is taken until it ends. Reset clears the control state and loads the
// markers with 0x55 and 0xAA; the payload store is not cleared, as only entries
// written in a frame are read.
module serial_command_frame_parser (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [scfp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        rx_byte,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        frame_command,
	output logic [7:0]                        frame_length,
	output logic                              has_payload,
	output logic [7:0]                        payload_byte,
	output logic [4:0]                        payload_position,
	output logic                              last_of_frame
);

	scfp_pkg::cmd_t cmd;
	scfp_pkg::sts_t sts;

	// Frame controller.
	scfp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Payload store, header registers and output word.
	scfp_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_wen          (cfg_wen),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.rx_byte          (rx_byte),
		.cmd              (cmd),
		.sts              (sts),
		.out_ready        (out_ready),
		.out_valid        (out_valid),
		.frame_command    (frame_command),
		.frame_length     (frame_length),
		.has_payload      (has_payload),
		.payload_byte     (payload_byte),
		.payload_position (payload_position),
		.last_of_frame    (last_of_frame)
	);

`ifndef SYNTHESIS
	// A word with no payload is always the only and final word of its frame.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !has_payload |-> last_of_frame)
		else $error("word without payload not marked last");

	// While a frame is still draining, no receive word may be taken.
	a_no_rx_mid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> !in_ready)
		else $error("receive side open while frame is draining");

	// Loading an output word only happens outside the receive phases.
	a_load_blocks_rx: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !in_ready)
		else $error("output load while receiving");

	// A non-final word never sits at the last store position.
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_of_frame |-> payload_position != 5'(scfp_pkg::STORE_SIZE - 1))
		else $error("payload position overruns the store");
`endif

endmodule
